// ----- src/magic_square_sum_checker_defines.svh -----
// ----------------------------------------------------------------------------
// Magic square sum checker assertion macros
// Shared helpers that build clocked properties with a reset disable.
// ----------------------------------------------------------------------------
`ifndef MAGIC_SQUARE_SUM_CHECKER_DEFINES_SVH
`define MAGIC_SQUARE_SUM_CHECKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSSC_ASSERT_SAME(LBL, CLK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error("mssc property failed");

// Consequent must hold in the cycle after the antecedent.
`define MSSC_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error("mssc property failed");

`endif

// ----- src/mssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Magic square sum checker package
// Sizes, register codes and helper functions shared by the design files.
// ----------------------------------------------------------------------------
package mssc_pkg;

    localparam int MAX_SIDE = 16;
    localparam int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);

    localparam int VAL_W   = 16;
    localparam int SUM_W   = 20;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(3);

    localparam logic REG_SIDE_LENGTH = 1'b0;

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIDE_W-1:0] t_side;

    function automatic t_side eff_side(input logic [CFG_W-1:0] side);
        t_side res;
        if (side == '0) begin
            res = SIDE_W'(1);
        end else if (32'(side) > MAX_SIDE) begin
            res = SIDE_W'(MAX_SIDE);
        end else begin
            res = SIDE_W'(side);
        end
        return res;
    endfunction

endpackage

// ----- src/magic_square_sum_checker.sv -----
// ----------------------------------------------------------------------------
// Magic square sum checker
// Accumulates row, column and diagonal sums of a square grid and reports
// them per index once the grid is complete, with a magic square flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Word
//  input     in         i_in_valid / o_in_ready     i_value
//  output    out        o_out_valid / i_out_ready   o_index .. o_last
//  config    in         psel, penable, pwrite       side_length at byte 0
//
// One grid element is taken per cycle while in the run state; the column store is
// a read-modify-write memory with registered reads and a forwarding register.
// After the final element there is a drain state, then each result passes a memory
// read state and then an output register load, which waits while the sink stalls.
// Reset is synchronous; no clearing pass is needed.
// A stalled output holds the walk; input is taken again after the last result loads.
// ----------------------------------------------------------------------------
module magic_square_sum_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [mssc_pkg::VAL_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mssc_pkg::INDEX_W-1:0]  o_index,
    output logic signed [mssc_pkg::SUM_W-1:0]   o_row_sum,
    output logic signed [mssc_pkg::SUM_W-1:0]   o_column_sum,
    output logic signed [mssc_pkg::SUM_W-1:0]   o_diagonal_sum,
    output logic signed [mssc_pkg::SUM_W-1:0]   o_anti_diagonal_sum,
    output logic                          o_is_magic,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mssc_pkg::ADDR_W-1:0]   paddr,
    input  logic [mssc_pkg::DATA_W-1:0]   pwdata,
    output logic [mssc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mssc_pkg::*;

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_ERD   = 2'd2;
    localparam logic [1:0] S_ELD   = 2'd3;

    logic [1:0]        r_state;
    logic [CFG_W-1:0]  r_side;
    t_sum              r_run;
    t_sum              r_diag;
    t_sum              r_anti;
    t_idx              r_row;
    t_idx              r_col;
    t_idx              r_k;
    logic              r_magic;
    logic [MAX_SIDE-1:0] r_col_ok;

    logic              r_s1_vld;
    t_idx              r_s1_col;
    t_sum              r_s1_val;
    logic              r_wb_vld;
    t_idx              r_wb_col;
    t_sum              r_wb_data;

    t_sum              r_col_mem [MAX_SIDE];
    t_sum              r_row_mem [MAX_SIDE];
    t_sum              r_col_rd;
    t_sum              r_row_rd;

    logic              r_out_valid;
    logic [INDEX_W-1:0] r_o_index;
    t_sum              r_o_row;
    t_sum              r_o_col;
    t_sum              r_o_diag;
    t_sum              r_o_anti;
    logic              r_o_magic;
    logic              r_o_last;

    t_side             side_eff;
    t_idx              last_idx;
    t_side             anti_pos;
    logic              accept;
    logic              cfg_wr;
    logic              col_end;
    logic              row_end;
    logic              on_main;
    logic              on_anti;
    t_sum              v_ext;
    t_sum              row_total;
    t_sum              n_diag;
    t_sum              n_anti;
    t_idx              rd_addr;
    t_sum              col_old;
    t_sum              s1_sum;
    t_sum              row_v;
    t_sum              col_v;
    logic              magic_now;
    logic              load_out;
    logic              k_last;

    assign side_eff  = eff_side(r_side);
    assign last_idx  = IDX_W'(side_eff - SIDE_W'(1));
    assign anti_pos  = SIDE_W'(side_eff - SIDE_W'(1) - SIDE_W'(r_row));

    assign o_in_ready = (r_state == S_RUN);
    assign accept     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite && pready
                        && (paddr[ADDR_W-1] == REG_SIDE_LENGTH);

    assign col_end   = (r_col == last_idx);
    assign row_end   = (r_row == last_idx);
    assign on_main   = (r_col == r_row);
    assign on_anti   = (SIDE_W'(r_col) == anti_pos);
    assign v_ext     = {{(SUM_W-VAL_W){i_value[VAL_W-1]}}, i_value};
    assign row_total = r_run + v_ext;
    assign n_diag    = on_main ? (r_diag + v_ext) : r_diag;
    assign n_anti    = on_anti ? (r_anti + v_ext) : r_anti;

    assign rd_addr = (r_state == S_RUN) ? r_col : r_k;

    assign col_old = (r_wb_vld && (r_wb_col == r_s1_col)) ? r_wb_data
                   : (r_col_ok[r_s1_col] ? r_col_rd : '0);
    assign s1_sum  = col_old + r_s1_val;

    assign row_v     = r_row_rd;
    assign col_v     = r_col_ok[r_k] ? r_col_rd : '0;
    assign k_last    = (r_k == last_idx);
    assign magic_now = r_magic && (row_v == r_diag) && (col_v == r_diag);
    assign load_out  = (r_state == S_ELD) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        r_col_rd <= r_col_mem[rd_addr];
        r_row_rd <= r_row_mem[r_k];
        if (r_s1_vld) begin
            r_col_mem[r_s1_col] <= s1_sum;
        end
        if (accept && col_end) begin
            r_row_mem[r_row] <= row_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col  <= r_col;
        r_s1_val  <= v_ext;
        r_wb_col  <= r_s1_col;
        r_wb_data <= s1_sum;
        if (load_out) begin
            r_o_index <= INDEX_W'(r_k);
            r_o_row   <= row_v;
            r_o_col   <= col_v;
            r_o_diag  <= r_diag;
            r_o_anti  <= r_anti;
            r_o_magic <= k_last && magic_now;
            r_o_last  <= k_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_side      <= SIDE_RESET;
            r_run       <= '0;
            r_diag      <= '0;
            r_anti      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_magic     <= 1'b0;
            r_col_ok    <= '0;
            r_s1_vld    <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_wb_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_col_ok[r_s1_col] <= 1'b1;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_RUN: begin
                    if (accept) begin
                        r_diag <= n_diag;
                        r_anti <= n_anti;
                        if (col_end) begin
                            r_run <= '0;
                            r_col <= '0;
                            if (row_end) begin
                                r_row   <= '0;
                                r_k     <= '0;
                                r_magic <= (n_diag == n_anti);
                                r_state <= S_DRAIN;
                            end else begin
                                r_row <= IDX_W'(r_row + 1'b1);
                            end
                        end else begin
                            r_run <= row_total;
                            r_col <= IDX_W'(r_col + 1'b1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_ERD;
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    if (load_out) begin
                        r_magic <= magic_now;
                        if (k_last) begin
                            r_diag   <= '0;
                            r_anti   <= '0;
                            r_col_ok <= '0;
                            r_state  <= S_RUN;
                        end else begin
                            r_k     <= IDX_W'(r_k + 1'b1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase

            if (cfg_wr) begin
                r_side   <= pwdata[CFG_W-1:0];
                r_run    <= '0;
                r_diag   <= '0;
                r_anti   <= '0;
                r_row    <= '0;
                r_col    <= '0;
                r_col_ok <= '0;
            end
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_SIDE_LENGTH)
                  ? {{(DATA_W-CFG_W){1'b0}}, r_side} : '0;
    assign pready = 1'b1;

    assign o_out_valid         = r_out_valid;
    assign o_index             = r_o_index;
    assign o_row_sum           = r_o_row;
    assign o_column_sum        = r_o_col;
    assign o_diagonal_sum      = r_o_diag;
    assign o_anti_diagonal_sum = r_o_anti;
    assign o_is_magic          = r_o_magic;
    assign o_last              = r_o_last;

endmodule

// ----- src/mssc_checker.sv -----
// ----------------------------------------------------------------------------
// Magic square sum checker port checker
// Watches the top level ports for ordering of results and the output word.
// ----------------------------------------------------------------------------
`include "magic_square_sum_checker_defines.svh"

module mssc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mssc_pkg::INDEX_W-1:0]  o_index,
    input logic                          o_is_magic,
    input logic                          o_last
);
    import mssc_pkg::*;

    `MSSC_ASSERT_SAME(a_magic_on_last, i_clk, i_rst_n, o_out_valid && o_is_magic, o_last)
    `MSSC_ASSERT_SAME(a_no_input_mid_walk, i_clk, i_rst_n, o_out_valid && !o_last, !o_in_ready)
    `MSSC_ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, !o_out_valid || (o_index == $past(o_index) + INDEX_W'(1)))
    `MSSC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_index) && $stable(o_last))

endmodule

bind magic_square_sum_checker mssc_checker u_mssc_checker (.*);
